>>> src/cief_pkg.sv
// shared types and constants for the coalescing input event fifo
package cief_pkg;

  localparam int unsigned QueueDepthDef = 512;

  localparam logic FUNC_PUSH = 1'b0;
  localparam logic FUNC_POP  = 1'b1;

  localparam logic [1:0] KIND_KEY   = 2'd0;
  localparam logic [1:0] KIND_MOVE  = 2'd1;
  localparam logic [1:0] KIND_WHEEL = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_WRITE,
    ST_RESULT
  } cief_state_e;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [7:0]  buttons;
    logic [7:0]  key_code;
    logic [7:0]  key_pressed;
    logic [31:0] delta_x;
    logic [31:0] delta_y;
  } cief_entry_t;

  typedef struct packed {
    logic latch;
    logic rd;
    logic wr;
    logic emit;
  } cief_cmd_t;

  typedef struct packed {
    logic is_pop;
  } cief_status_t;

  function automatic logic [31:0] sat_add32(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {a[31], a} + {b[31], b};
    if (s[32] != s[31]) begin
      sat_add32 = s[32] ? 32'h8000_0000 : 32'h7fff_ffff;
    end else begin
      sat_add32 = s[31:0];
    end
  endfunction

endpackage

>>> src/cief_ctrl.sv
// controller state machine for the coalescing input event fifo
module cief_ctrl import cief_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic         func_i,
  input  logic [1:0]   event_kind_i,
  input  cief_status_t status_i,
  output cief_cmd_t    cmd_o,
  output logic         busy_o
);

  cief_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy_o  = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o.latch = 1'b1;
          // a push of the reserved kind is taken and dropped
          if (func_i == FUNC_POP || event_kind_i == KIND_KEY ||
              event_kind_i == KIND_MOVE || event_kind_i == KIND_WHEEL) begin
            state_d = ST_READ;
          end
        end
      end
      ST_READ: begin
        cmd_o.rd = 1'b1;
        state_d  = status_i.is_pop ? ST_RESULT : ST_WRITE;
      end
      ST_WRITE: begin
        cmd_o.wr = 1'b1;
        state_d  = ST_IDLE;
      end
      ST_RESULT: begin
        cmd_o.emit = 1'b1;
        state_d    = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

>>> src/cief_dpath.sv
// datapath: event ring memory, ring indices, merge and result logic
module cief_dpath import cief_pkg::*; #(
  parameter int unsigned QueueDepth = QueueDepthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cief_cmd_t           cmd_i,
  output cief_status_t        status_o,
  input  logic                func_i,
  input  logic [1:0]          event_kind_i,
  input  logic signed [15:0]  pos_x_i,
  input  logic signed [15:0]  pos_y_i,
  input  logic signed [31:0]  delta_x_i,
  input  logic signed [31:0]  delta_y_i,
  input  logic [7:0]          buttons_i,
  input  logic [7:0]          key_code_i,
  input  logic [7:0]          key_pressed_i,
  output logic                valid_o,
  output logic                available_o,
  output logic [1:0]          out_kind_o,
  output logic signed [15:0]  out_pos_x_o,
  output logic signed [15:0]  out_pos_y_o,
  output logic signed [31:0]  out_delta_x_o,
  output logic signed [31:0]  out_delta_y_o,
  output logic [7:0]          out_buttons_o,
  output logic [7:0]          out_key_code_o,
  output logic [7:0]          out_key_pressed_o
);

  localparam int unsigned AW = $clog2(QueueDepth);
  localparam logic [AW-1:0] LastIdx = AW'(QueueDepth - 1);

  cief_entry_t mem [QueueDepth];
  cief_entry_t rdata_q;
  cief_entry_t word_q, word_d;
  logic        func_q;
  logic        empty_q;
  logic [AW-1:0] wr_idx_q, wr_idx_d, rd_idx_q, rd_idx_d;
  logic [AW-1:0] wr_next, wr_prev, rd_next, rd_addr, wr_addr;
  logic        merge;
  cief_entry_t wdata;

  assign wr_next = (wr_idx_q == LastIdx) ? '0 : wr_idx_q + AW'(1);
  assign wr_prev = (wr_idx_q == '0) ? LastIdx : wr_idx_q - AW'(1);
  assign rd_next = (rd_idx_q == LastIdx) ? '0 : rd_idx_q + AW'(1);

  // unused fields of a kind are stored as zero
  always_comb begin
    word_d         = '0;
    word_d.kind    = event_kind_i;
    case (event_kind_i)
      KIND_KEY: begin
        word_d.key_code    = key_code_i;
        word_d.key_pressed = key_pressed_i;
      end
      KIND_MOVE: begin
        word_d.pos_x   = pos_x_i;
        word_d.pos_y   = pos_y_i;
        word_d.buttons = buttons_i;
        word_d.delta_x = delta_x_i;
        word_d.delta_y = delta_y_i;
      end
      default: begin
        word_d.pos_x   = pos_x_i;
        word_d.pos_y   = pos_y_i;
        word_d.buttons = buttons_i;
        word_d.delta_y = delta_y_i;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      word_q <= word_d;
      func_q <= func_i;
    end
  end

  assign status_o.is_pop = (func_q == FUNC_POP);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      empty_q <= 1'b1;
    end else if (cmd_i.latch) begin
      empty_q <= (wr_idx_q == rd_idx_q);
    end
  end

  // pops read the oldest entry, pushes read the newest one
  assign rd_addr = status_o.is_pop ? rd_idx_q : wr_prev;

  assign merge = (word_q.kind == KIND_MOVE) && !empty_q &&
                 (rdata_q.kind == KIND_MOVE) && (rdata_q.buttons == word_q.buttons);

  always_comb begin
    wdata   = word_q;
    wr_addr = wr_idx_q;
    if (merge) begin
      wr_addr       = wr_prev;
      wdata.delta_x = sat_add32(rdata_q.delta_x, word_q.delta_x);
      wdata.delta_y = sat_add32(rdata_q.delta_y, word_q.delta_y);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr) begin
      mem[wr_addr] <= wdata;
    end
    if (cmd_i.rd) begin
      rdata_q <= mem[rd_addr];
    end
  end

  always_comb begin
    wr_idx_d = wr_idx_q;
    rd_idx_d = rd_idx_q;
    if (cmd_i.wr && !merge) begin
      wr_idx_d = wr_next;
      // ring full: drop the oldest word
      if (wr_next == rd_idx_q) begin
        rd_idx_d = rd_next;
      end
    end
    if (cmd_i.emit && !empty_q) begin
      rd_idx_d = rd_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_idx_q <= '0;
      rd_idx_q <= '0;
    end else begin
      wr_idx_q <= wr_idx_d;
      rd_idx_q <= rd_idx_d;
    end
  end

  assign valid_o           = cmd_i.emit;
  assign available_o       = !empty_q;
  assign out_kind_o        = empty_q ? '0 : rdata_q.kind;
  assign out_pos_x_o       = empty_q ? '0 : rdata_q.pos_x;
  assign out_pos_y_o       = empty_q ? '0 : rdata_q.pos_y;
  assign out_delta_x_o     = empty_q ? '0 : rdata_q.delta_x;
  assign out_delta_y_o     = empty_q ? '0 : rdata_q.delta_y;
  assign out_buttons_o     = empty_q ? '0 : rdata_q.buttons;
  assign out_key_code_o    = empty_q ? '0 : rdata_q.key_code;
  assign out_key_pressed_o = empty_q ? '0 : rdata_q.key_pressed;

endmodule

>>> src/coalescing_input_event_fifo.sv
// a pop's word appears on the outputs, strobed by valid_o, in the result state after its read
// a push is busy in the read and write states; a new item waits for the last one's steps
// (idle, memory read, then write or result), a reserved-kind push every cycle
// the pace is set by the single-port read of the ring memory before each write or result
// reset clears the ring indices and the controller; the ring memory is not cleared
// results are not held: valid_o is high for one cycle and the receiver cannot stall
module coalescing_input_event_fifo import cief_pkg::*; #(
  parameter int unsigned QueueDepth = QueueDepthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic                func_i,
  input  logic [1:0]          event_kind_i,
  input  logic signed [15:0]  pos_x_i,
  input  logic signed [15:0]  pos_y_i,
  input  logic signed [31:0]  delta_x_i,
  input  logic signed [31:0]  delta_y_i,
  input  logic [7:0]          buttons_i,
  input  logic [7:0]          key_code_i,
  input  logic [7:0]          key_pressed_i,
  output logic                valid_o,
  output logic                available_o,
  output logic [1:0]          out_kind_o,
  output logic signed [15:0]  out_pos_x_o,
  output logic signed [15:0]  out_pos_y_o,
  output logic signed [31:0]  out_delta_x_o,
  output logic signed [31:0]  out_delta_y_o,
  output logic [7:0]          out_buttons_o,
  output logic [7:0]          out_key_code_o,
  output logic [7:0]          out_key_pressed_o
);

  cief_cmd_t    cmd;
  cief_status_t status;

  cief_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .func_i       (func_i),
    .event_kind_i (event_kind_i),
    .status_i     (status),
    .cmd_o        (cmd),
    .busy_o       (busy)
  );

  cief_dpath #(
    .QueueDepth (QueueDepth)
  ) u_dpath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .func_i            (func_i),
    .event_kind_i      (event_kind_i),
    .pos_x_i           (pos_x_i),
    .pos_y_i           (pos_y_i),
    .delta_x_i         (delta_x_i),
    .delta_y_i         (delta_y_i),
    .buttons_i         (buttons_i),
    .key_code_i        (key_code_i),
    .key_pressed_i     (key_pressed_i),
    .valid_o           (valid_o),
    .available_o       (available_o),
    .out_kind_o        (out_kind_o),
    .out_pos_x_o       (out_pos_x_o),
    .out_pos_y_o       (out_pos_y_o),
    .out_delta_x_o     (out_delta_x_o),
    .out_delta_y_o     (out_delta_y_o),
    .out_buttons_o     (out_buttons_o),
    .out_key_code_o    (out_key_code_o),
    .out_key_pressed_o (out_key_pressed_o)
  );

endmodule

>>> verif/tb_coalescing_input_event_fifo.sv
`timescale 1ns / 1ps
// self-checking testbench for the coalescing input event fifo
module tb_coalescing_input_event_fifo;
  import cief_pkg::*;

  localparam int unsigned Depth = QueueDepthDef;
  localparam logic [1:0] KindReserved = 2'd3;
  localparam int unsigned IdleLimit = 2000;
  localparam int unsigned TailCycles = 16;
  localparam int unsigned ItemTarget = 800;
  localparam int unsigned MaxPrinted = 50;

  // field order matches the concatenation onto the input ports below
  typedef struct packed {
    logic        func;
    logic [1:0]  kind;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [31:0] delta_x;
    logic [31:0] delta_y;
    logic [7:0]  buttons;
    logic [7:0]  key_code;
    logic [7:0]  key_pressed;
  } event_word_t;

  typedef struct packed {
    logic        available;
    cief_entry_t entry;
  } pop_word_t;

  class event_ring_scoreboard;
    cief_entry_t ring [Depth];
    int unsigned head_idx;
    int unsigned tail_idx;
    pop_word_t   due_pops [$];
    int unsigned errors;
    int unsigned checked;

    function new();
      head_idx = 0;
      tail_idx = 0;
      errors = 0;
      checked = 0;
    endfunction

    task report(string msg);
      errors++;
      // keep the log short when the design is badly broken
      if (errors <= MaxPrinted) $display("%0t: %s", $time, msg);
    endtask

    static function logic [31:0] clamp_add(logic [31:0] a, logic [31:0] b);
      longint sum;
      sum = longint'($signed(a)) + longint'($signed(b));
      if (sum > 64'sd2147483647) return 32'h7fff_ffff;
      if (sum < -64'sd2147483648) return 32'h8000_0000;
      return 32'(sum);
    endfunction

    function void note_word(event_word_t w);
      pop_word_t   due;
      cief_entry_t ent;
      int unsigned newest;
      if (w.func == FUNC_POP) begin
        due = '0;
        if (head_idx != tail_idx) begin
          due.available = 1'b1;
          due.entry = ring[head_idx];
          head_idx = (head_idx + 1) % Depth;
        end
        due_pops.push_back(due);
        return;
      end
      ent = '0;
      ent.kind = w.kind;
      if (w.kind == KIND_KEY) begin
        ent.key_code = w.key_code;
        ent.key_pressed = w.key_pressed;
      end else if (w.kind == KIND_MOVE || w.kind == KIND_WHEEL) begin
        ent.pos_x = w.pos_x;
        ent.pos_y = w.pos_y;
        ent.buttons = w.buttons;
        ent.delta_y = w.delta_y;
        if (w.kind == KIND_MOVE) ent.delta_x = w.delta_x;
      end else begin
        return;
      end
      newest = (tail_idx + Depth - 1) % Depth;
      if (w.kind == KIND_MOVE && head_idx != tail_idx && ring[newest].kind == KIND_MOVE &&
          ring[newest].buttons == w.buttons) begin
        ent.delta_x = clamp_add(ring[newest].delta_x, w.delta_x);
        ent.delta_y = clamp_add(ring[newest].delta_y, w.delta_y);
        ring[newest] = ent;
        return;
      end
      // ring full: the oldest entry goes
      if ((tail_idx + 1) % Depth == head_idx) head_idx = (head_idx + 1) % Depth;
      ring[tail_idx] = ent;
      tail_idx = (tail_idx + 1) % Depth;
    endfunction

    task cmp_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want) begin
        report($sformatf("word %0d: %s is %h, %h due", checked, name, got, want));
      end
    endtask

    task check_word(logic available, logic [1:0] kind, logic [15:0] pos_x,
                    logic [15:0] pos_y, logic [31:0] delta_x, logic [31:0] delta_y,
                    logic [7:0] buttons, logic [7:0] key_code, logic [7:0] key_pressed);
      pop_word_t due;
      checked++;
      if (due_pops.size() == 0) begin
        report($sformatf("word %0d arrived with no pop outstanding", checked));
        return;
      end
      due = due_pops.pop_front();
      cmp_field("available", 32'(available), 32'(due.available));
      cmp_field("kind", 32'(kind), 32'(due.entry.kind));
      cmp_field("pos_x", 32'(pos_x), 32'(due.entry.pos_x));
      cmp_field("pos_y", 32'(pos_y), 32'(due.entry.pos_y));
      cmp_field("delta_x", delta_x, due.entry.delta_x);
      cmp_field("delta_y", delta_y, due.entry.delta_y);
      cmp_field("buttons", 32'(buttons), 32'(due.entry.buttons));
      cmp_field("key_code", 32'(key_code), 32'(due.entry.key_code));
      cmp_field("key_pressed", 32'(key_pressed), 32'(due.entry.key_pressed));
    endtask
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  event_word_t        drive_word = '0;
  logic               func_i;
  logic [1:0]         event_kind_i;
  logic signed [15:0] pos_x_i;
  logic signed [15:0] pos_y_i;
  logic signed [31:0] delta_x_i;
  logic signed [31:0] delta_y_i;
  logic [7:0]         buttons_i;
  logic [7:0]         key_code_i;
  logic [7:0]         key_pressed_i;
  logic               valid_o;
  logic               available_o;
  logic [1:0]         out_kind_o;
  logic signed [15:0] out_pos_x_o;
  logic signed [15:0] out_pos_y_o;
  logic signed [31:0] out_delta_x_o;
  logic signed [31:0] out_delta_y_o;
  logic [7:0]         out_buttons_o;
  logic [7:0]         out_key_code_o;
  logic [7:0]         out_key_pressed_o;

  event_ring_scoreboard ring_sb = new();
  int unsigned n_items = 0;
  int unsigned idle_cycles = 0;
  bit          no_gap = 1'b0;
  logic [7:0]  last_btn = 8'h00;

  assign {func_i, event_kind_i, pos_x_i, pos_y_i, delta_x_i, delta_y_i, buttons_i,
          key_code_i, key_pressed_i} = drive_word;

  always #1 clk_i = ~clk_i;

  coalescing_input_event_fifo dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (start),
    .busy              (busy),
    .func_i            (func_i),
    .event_kind_i      (event_kind_i),
    .pos_x_i           (pos_x_i),
    .pos_y_i           (pos_y_i),
    .delta_x_i         (delta_x_i),
    .delta_y_i         (delta_y_i),
    .buttons_i         (buttons_i),
    .key_code_i        (key_code_i),
    .key_pressed_i     (key_pressed_i),
    .valid_o           (valid_o),
    .available_o       (available_o),
    .out_kind_o        (out_kind_o),
    .out_pos_x_o       (out_pos_x_o),
    .out_pos_y_o       (out_pos_y_o),
    .out_delta_x_o     (out_delta_x_o),
    .out_delta_y_o     (out_delta_y_o),
    .out_buttons_o     (out_buttons_o),
    .out_key_code_o    (out_key_code_o),
    .out_key_pressed_o (out_key_pressed_o)
  );

  // monitor and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) ring_sb.note_word(drive_word);
      if (valid_o) begin
        ring_sb.check_word(available_o, out_kind_o, out_pos_x_o, out_pos_y_o, out_delta_x_o,
                           out_delta_y_o, out_buttons_o, out_key_code_o, out_key_pressed_o);
      end
      if ((start && !busy) || valid_o) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
        $display("coalescing_input_event_fifo regression: fail");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  function automatic logic [31:0] pick_delta();
    case ($urandom_range(0, 9))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'hffff_ffff;
      3: return 32'h0000_0001;
      4, 5: return 32'($urandom_range(0, 400)) - 32'd200;
      default: return $urandom;
    endcase
  endfunction

  function automatic event_word_t any_word();
    event_word_t w;
    w.func = 1'($urandom_range(0, 1));
    w.kind = 2'($urandom_range(0, 3));
    w.pos_x = 16'($urandom);
    w.pos_y = 16'($urandom);
    w.delta_x = $urandom;
    w.delta_y = $urandom;
    w.buttons = 8'($urandom);
    w.key_code = 8'($urandom);
    w.key_pressed = 8'($urandom);
    return w;
  endfunction

  function automatic event_word_t pop_word();
    event_word_t w;
    w = any_word();
    w.func = FUNC_POP;
    return w;
  endfunction

  function automatic event_word_t push_word(logic [1:0] kind, logic [15:0] px, logic [15:0] py,
                                            logic [31:0] dx, logic [31:0] dy, logic [7:0] btn,
                                            logic [7:0] code, logic [7:0] pressed);
    return '{func: FUNC_PUSH, kind: kind, pos_x: px, pos_y: py, delta_x: dx, delta_y: dy,
             buttons: btn, key_code: code, key_pressed: pressed};
  endfunction

  // merge_pct steers how often a pointer move reuses the last mask and so coalesces
  function automatic event_word_t random_word(int unsigned push_pct, int unsigned merge_pct);
    event_word_t w;
    int unsigned pick;
    w = any_word();
    w.func = ($urandom_range(0, 99) < push_pct) ? FUNC_PUSH : FUNC_POP;
    pick = $urandom_range(0, 99);
    w.kind = (pick < 25) ? KIND_KEY : (pick < 70) ? KIND_MOVE :
             (pick < 95) ? KIND_WHEEL : KindReserved;
    w.delta_x = pick_delta();
    w.delta_y = pick_delta();
    if (w.func == FUNC_PUSH && w.kind == KIND_MOVE) begin
      if ($urandom_range(0, 99) < merge_pct) w.buttons = last_btn;
      last_btn = w.buttons;
    end
    return w;
  endfunction

  // hold start until the word is taken, then drop it only before a gap or a drain; drain waits for every pop result
  task automatic issue(event_word_t w, bit drain);
    int unsigned gap;
    gap = no_gap ? 0 : $urandom_range(0, 15);
    start <= 1'b1;
    drive_word <= w;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    if (!(w.func == FUNC_PUSH && w.kind == KindReserved)) n_items++;
    if (n_items % 40 == 0) no_gap = ($urandom_range(0, 3) == 0);
    if (gap != 0 || drain) start <= 1'b0;
    repeat (gap) @(posedge clk_i);
    if (drain) begin
      @(posedge clk_i);
      while (ring_sb.due_pops.size() != 0) @(posedge clk_i);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    issue(pop_word(), 1'b0);
    // key words carry junk in the pointer fields, which must read back as zero
    issue(push_word(KIND_KEY, 16'h7fff, 16'h8000, 32'h7fff_ffff, 32'h8000_0000, 8'hff,
                    8'hff, 8'hff), 1'b0);
    issue(push_word(KIND_KEY, 16'hffff, 16'hffff, 32'hffff_ffff, 32'hffff_ffff, 8'h00,
                    8'h00, 8'h00), 1'b0);
    issue(push_word(KIND_MOVE, 16'h7fff, 16'h8000, 32'h7fff_ffff, 32'h8000_0000, 8'hff,
                    8'hff, 8'hff), 1'b0);
    // same mask: merge, both deltas pinned at the limits
    issue(push_word(KIND_MOVE, 16'h8000, 16'h7fff, 32'h0000_0001, 32'hffff_ffff, 8'hff,
                    8'h5a, 8'ha5), 1'b0);
    issue(push_word(KIND_MOVE, 16'h0000, 16'hffff, 32'h8000_0000, 32'h7fff_ffff, 8'hff,
                    8'h00, 8'h00), 1'b0);
    issue(push_word(KIND_MOVE, 16'h1234, 16'h4321, 32'h8000_0000, 32'h8000_0000, 8'h00,
                    8'h00, 8'h00), 1'b0);
    issue(push_word(KIND_MOVE, 16'h0001, 16'h0002, 32'h8000_0000, 32'hffff_ffff, 8'h00,
                    8'h00, 8'h00), 1'b0);
    issue(push_word(KIND_WHEEL, 16'h8000, 16'h7fff, 32'h7fff_ffff, 32'h8000_0000, 8'h00,
                    8'hff, 8'hff), 1'b0);
    // a move after a wheel entry is appended
    issue(push_word(KIND_MOVE, 16'h0000, 16'h0000, 32'd5, 32'd5, 8'h00, 8'h00, 8'h00), 1'b0);
    issue(push_word(KindReserved, 16'hffff, 16'hffff, 32'hffff_ffff, 32'hffff_ffff, 8'hff,
                    8'hff, 8'hff), 1'b0);
    issue(push_word(KIND_MOVE, 16'h0001, 16'h0001, 32'd7, 32'd7, 8'h00, 8'h00, 8'h00), 1'b0);
    repeat (7) issue(pop_word(), 1'b0);
    // stale move in the ring must not be merged into once the queue is empty
    issue(push_word(KIND_MOVE, 16'h0010, 16'h0020, 32'd3, 32'd4, 8'h3c, 8'h00, 8'h00), 1'b0);
    issue(pop_word(), 1'b0);
    issue(push_word(KIND_MOVE, 16'h0030, 16'h0040, 32'd9, 32'd9, 8'h3c, 8'h00, 8'h00), 1'b0);
    issue(pop_word(), 1'b1);

    while (n_items < 150) issue(random_word(50, 60), 1'b0);
    issue(pop_word(), 1'b1);
    // push-only flood so the ring fills and starts dropping the oldest word
    repeat (Depth + 80) issue(random_word(100, 10), 1'b0);
    while (n_items < ItemTarget) issue(random_word(35, 60), 1'b0);
    issue(pop_word(), 1'b1);
    repeat (TailCycles) @(posedge clk_i);

    if (ring_sb.errors == 0) begin
      $display("coalescing_input_event_fifo regression: pass");
    end else begin
      $display("coalescing_input_event_fifo regression: fail");
    end
    $finish;
  end

endmodule

>>> files.f
src/cief_pkg.sv
src/cief_ctrl.sv
src/cief_dpath.sv
src/coalescing_input_event_fifo.sv
verif/tb_coalescing_input_event_fifo.sv
